// File: design/calm_pkg.sv
// ----------------------------------------------------------------------------
// calm_pkg: shared types, codes and helpers for the CIDR allow-list matcher
// Controller states, datapath command bundle, operation codes and the
// prefix-mask helpers used by the scan compare.
// ----------------------------------------------------------------------------
package calm_pkg;

    localparam int DEF_MAX_ENTRIES = 16;

    localparam int ADDR_W    = 128;
    localparam int HALF_W    = 64;
    localparam int PLEN_W    = 8;
    localparam int IDX_IN_W  = 4;
    localparam int USE_W     = 5;

    localparam logic [PLEN_W-1:0] V4_MAX_PLEN = 8'd32;
    localparam logic [PLEN_W-1:0] V6_MAX_PLEN = 8'd128;
    // IPv4 lives in the low 32 bits of the 128-bit word
    localparam logic [PLEN_W-1:0] V4_PLEN_OFS = 8'd96;
    localparam logic [HALF_W-1:0] V4_LOW_MASK = 64'h0000_0000_ffff_ffff;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic load_query;  // latch query fields, clear hit
        logic wr_en;       // store one list entry
        logic rd_en;       // read one list entry for compare
    } t_dp_cmd;

    function automatic logic prefix_ok(input logic fam4, input logic [PLEN_W-1:0] plen);
        return fam4 ? (plen <= V4_MAX_PLEN) : (plen <= V6_MAX_PLEN);
    endfunction

    // Leading-ones mask: bit j set when it lies within the first eff bits
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] eff);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int j = 0; j < ADDR_W; j++) begin
            m[j] = (eff > PLEN_W'(ADDR_W - 1 - j));
        end
        return m;
    endfunction

endpackage

// File: design/calm_dp.sv
// ----------------------------------------------------------------------------
// calm_dp: entry table and compare datapath
// Holds the allow-list entries in a memory with valid flags in flops, the
// latched query, and a one-entry-per-cycle containment compare.
// ----------------------------------------------------------------------------
module calm_dp
    import calm_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [IDX_W-1:0]       i_rd_addr,
    input  logic [IDX_IN_W-1:0]    i_entry_index,
    input  logic                   i_entry_valid,
    input  logic                   i_is_ipv4,
    input  logic [HALF_W-1:0]      i_address_high,
    input  logic [HALF_W-1:0]      i_address_low,
    input  logic [PLEN_W-1:0]      i_prefix_length,
    output logic                   o_hit
);

    localparam int CNT_W   = (MAX_ENTRIES >= 32) ? $clog2(MAX_ENTRIES + 1) : USE_W;
    localparam int ENTRY_W = 1 + PLEN_W + ADDR_W;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic               r_vld [MAX_ENTRIES];

    logic [ENTRY_W-1:0] r_rd_word;
    logic               r_rd_ok;
    logic               r_cmp_en;
    logic               r_hit;
    logic               n_hit;

    logic               r_q_fam;
    logic [ADDR_W-1:0]  r_q_addr;
    logic [PLEN_W-1:0]  r_q_plen;
    logic               r_q_ok;

    logic [HALF_W-1:0]  in_high;
    logic [HALF_W-1:0]  in_low;
    logic [CNT_W-1:0]   wr_ext;
    logic               wr_in_range;
    logic [IDX_W-1:0]   wr_addr;

    logic               e_fam;
    logic [PLEN_W-1:0]  e_plen;
    logic [ADDR_W-1:0]  e_addr;
    logic [PLEN_W-1:0]  e_eff;
    logic               match;

    // Drop the unused upper bits of an IPv4 address
    always_comb begin
        in_high     = i_is_ipv4 ? '0 : i_address_high;
        in_low      = i_is_ipv4 ? (i_address_low & V4_LOW_MASK) : i_address_low;
        wr_ext      = CNT_W'(i_entry_index);
        wr_in_range = (wr_ext < CNT_W'(MAX_ENTRIES));
        wr_addr     = wr_ext[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_in_range) begin
            mem[wr_addr] <= {i_is_ipv4, i_prefix_length, in_high, in_low};
        end
        if (i_cmd.rd_en) begin
            r_rd_word <= mem[i_rd_addr];
        end
        if (i_cmd.load_query) begin
            r_q_fam  <= i_is_ipv4;
            r_q_addr <= {in_high, in_low};
            r_q_plen <= i_prefix_length;
            r_q_ok   <= prefix_ok(i_is_ipv4, i_prefix_length);
        end
    end

    // An entry with an out-of-range prefix is kept as not valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_ENTRIES; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_ok  <= 1'b0;
            r_cmp_en <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            if (i_cmd.wr_en && wr_in_range) begin
                r_vld[wr_addr] <= i_entry_valid & prefix_ok(i_is_ipv4, i_prefix_length);
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= r_vld[i_rd_addr];
            end
            r_cmp_en <= i_cmd.rd_en;
            r_hit    <= n_hit;
        end
    end

    always_comb begin
        e_fam  = r_rd_word[ENTRY_W-1];
        e_plen = r_rd_word[ADDR_W +: PLEN_W];
        e_addr = r_rd_word[ADDR_W-1:0];
        e_eff  = e_fam ? (e_plen + V4_PLEN_OFS) : e_plen;
        match  = r_cmp_en && r_rd_ok && r_q_ok && (e_fam == r_q_fam)
                 && (r_q_plen >= e_plen)
                 && (((e_addr ^ r_q_addr) & prefix_mask(e_eff)) == '0);
        if (i_cmd.load_query) begin
            n_hit = 1'b0;
        end else begin
            n_hit = r_hit | match;
        end
    end

    assign o_hit = r_hit;

endmodule

// File: design/calm_ctrl.sv
// ----------------------------------------------------------------------------
// calm_ctrl: sequencer for the CIDR allow-list matcher
// Holds the entries-in-use register, steps the scan address over the table
// and raises the result strobe when the scan is done.
// ----------------------------------------------------------------------------
module calm_ctrl
    import calm_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_operation,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [USE_W-1:0]   i_cfg_data,
    output t_dp_cmd            o_cmd,
    output logic [IDX_W-1:0]   o_rd_addr,
    output logic               o_done
);

    localparam int CNT_W = (MAX_ENTRIES >= 32) ? $clog2(MAX_ENTRIES + 1) : USE_W;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic [USE_W-1:0]   r_use;
    logic [CNT_W-1:0]   use_ext;
    logic [CNT_W-1:0]   n_lim;

    always_comb begin
        use_ext = CNT_W'(r_use);
        n_lim   = (use_ext > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : use_ext;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && (i_operation == OP_QUERY)) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_cnt >= n_lim) n_state = S_REPLY;
            end
            S_REPLY: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        busy             = (r_state != S_IDLE);
        o_cfg_ready      = (r_state == S_IDLE);
        o_done           = (r_state == S_REPLY);
        o_cmd.load_query = (r_state == S_IDLE) && start && (i_operation == OP_QUERY);
        o_cmd.wr_en      = (r_state == S_IDLE) && start && (i_operation == OP_WRITE);
        o_cmd.rd_en      = (r_state == S_SCAN) && (r_cnt < n_lim);
        o_rd_addr        = r_cnt[IDX_W-1:0];
        n_cnt            = r_cnt;
        if (o_cmd.load_query) begin
            n_cnt = '0;
        end else if (o_cmd.rd_en) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_use   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_use <= i_cfg_data;
            end
        end
    end

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_SCAN)
        else $error("result strobe without a finished scan");

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_query |=> (r_state == S_SCAN) && (r_cnt == '0))
        else $error("accepted query did not start a scan at entry zero");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_cnt < CNT_W'(MAX_ENTRIES)))
        else $error("table read beyond the last entry");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe held longer than one cycle");

endmodule

// File: design/cidr_allow_list_match.sv
// ----------------------------------------------------------------------------
// cidr_allow_list_match: CIDR allow-list containment matcher
// Write transaction: taken while idle, no result, block stays ready.
// Query transaction: busy while the entries in use are read one per cycle
// through the single memory read port, then for a compare step and a result
// step; the strobe sits in the result step and the next command is taken in
// the cycle after it. Receiver cannot stall. Sync active-low reset clears all
// valid flags.
// ----------------------------------------------------------------------------
module cidr_allow_list_match
    import calm_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // command channel: taken when start is high and busy is low
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_operation,
    input  logic [IDX_IN_W-1:0]  i_entry_index,
    input  logic                 i_entry_valid,
    input  logic                 i_is_ipv4,
    input  logic [HALF_W-1:0]    i_address_high,
    input  logic [HALF_W-1:0]    i_address_low,
    input  logic [PLEN_W-1:0]    i_prefix_length,
    // entries-in-use register write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [USE_W-1:0]     i_cfg_data,
    // result: one-cycle strobe, receiver cannot stall
    output logic                 o_done,
    output logic                 o_allowed
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_dp_cmd            cmd;
    logic [IDX_W-1:0]   rd_addr;

    // Sequencer: accept transactions, walk entries 0 .. in_use-1 (in_use capped at MAX_ENTRIES), strobe result
    calm_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_done      (o_done)
    );

    // Datapath: entry store, latched query, per-entry containment compare.
    // The hit flag is sticky over the scan and read out with the strobe.
    calm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rd_addr       (rd_addr),
        .i_entry_index   (i_entry_index),
        .i_entry_valid   (i_entry_valid),
        .i_is_ipv4       (i_is_ipv4),
        .i_address_high  (i_address_high),
        .i_address_low   (i_address_low),
        .i_prefix_length (i_prefix_length),
        .o_hit           (o_allowed)
    );

endmodule
